FILE: rtl/pid_controller_antiwindup_core_defines.svh
// assertion macros for the pid anti-windup core
`ifndef PID_CONTROLLER_ANTIWINDUP_CORE_DEFINES_SVH
`define PID_CONTROLLER_ANTIWINDUP_CORE_DEFINES_SVH
`ifndef SYNTHESIS
`define PAC_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("pac: same-cycle check failed");
`define PAC_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("pac: next-cycle check failed");
`else
`define PAC_ASSERT_NOW(label, ante, cons)
`define PAC_ASSERT_NEXT(label, ante, cons)
`endif
`endif

FILE: rtl/pac_pkg.sv
// shared types, constants and helpers of the pid anti-windup core
package pac_pkg;

   localparam int ERR_W     = 24;
   localparam int GAIN_W    = 16;
   localparam int STEP_W    = 10;
   localparam int OUT_W     = 16;
   localparam int FRAC_W    = 8;
   localparam int INTEG_W   = 48;
   localparam int DIFF_W    = ERR_W + 1;
   localparam int OPA_W     = GAIN_W + 1;
   localparam int OPB_W     = ERR_W + 1;
   localparam int PROD_W    = OPA_W + OPB_W;
   localparam int ACC_W     = 64;
   localparam int PD_W      = PROD_W;
   localparam int HI_SHIFT  = INTEG_W / 2;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DAT_W = 16;

   localparam logic [STEP_W-1:0]        STEP_TIME_RESET = STEP_W'(20);
   localparam logic signed [OUT_W-1:0]  OUT_MIN_RESET   = OUT_W'(-100 * 256);
   localparam logic signed [OUT_W-1:0]  OUT_MAX_RESET   = OUT_W'(100 * 256);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_GAIN_P    = 3'd0,
      CSR_GAIN_I    = 3'd1,
      CSR_GAIN_D    = 3'd2,
      CSR_STEP_TIME = 3'd3,
      CSR_OUT_MIN   = 3'd4,
      CSR_OUT_MAX   = 3'd5
   } csr_index_type;

   typedef enum logic [1:0] {
      MAC_HOLD,
      MAC_START,
      MAC_ADD,
      MAC_ADD_HI
   } mac_op_type;

   typedef struct packed {
      logic       mul_en;
      mac_op_type acc_op;
   } mac_ctl_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DIV,
      ST_MUL_EDT,
      ST_TRIAL,
      ST_MUL_KP,
      ST_ACC_KP,
      ST_MUL_KD,
      ST_ACC_KD,
      ST_MUL_KIL,
      ST_ACC_KIL,
      ST_MUL_KIH,
      ST_ACC_KIH,
      ST_CLAMP_SUM,
      ST_CLAMP_PD,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic                    hit;
      logic signed [OUT_W-1:0] value;
   } clamp_type;

   // clamp a q.16 sum to q8.8 limits, floor otherwise
   function automatic clamp_type clamp_q16(input logic signed [ACC_W-1:0] sum,
                                           input logic signed [OUT_W-1:0] lo,
                                           input logic signed [OUT_W-1:0] hi);
      logic signed [ACC_W-1:0] lo_q16;
      logic signed [ACC_W-1:0] hi_q16;
      clamp_type               r;
      lo_q16 = {{(ACC_W-OUT_W-FRAC_W){lo[OUT_W-1]}}, lo, {FRAC_W{1'b0}}};
      hi_q16 = {{(ACC_W-OUT_W-FRAC_W){hi[OUT_W-1]}}, hi, {FRAC_W{1'b0}}};
      r.hit   = 1'b0;
      r.value = sum[OUT_W+FRAC_W-1:FRAC_W];
      if (sum < lo_q16) begin
         r.value = lo;
         r.hit   = 1'b1;
      end
      if (sum > hi_q16) begin
         r.value = hi;
         r.hit   = 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: rtl/pac_div.sv
// serial restoring divider for the derivative term, one quotient bit per cycle
module pac_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [pac_pkg::DIFF_W-1:0]   dividend,
   input  logic        [pac_pkg::STEP_W-1:0]   divisor,
   output logic                                done,
   output logic signed [pac_pkg::DIFF_W-1:0]   quotient
);
   import pac_pkg::*;

   localparam int MAG_W = DIFF_W - 1;
   localparam int CNT_W = $clog2(MAG_W);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [STEP_W:0]          rem_ff, rem_in;
   logic [MAG_W-1:0]         quo_ff, quo_in;
   logic                     neg_ff, neg_in;
   logic [STEP_W-1:0]        dsr_ff, dsr_in;
   logic signed [DIFF_W-1:0] quot_ff, quot_in;
   logic [STEP_W:0]          shifted;
   logic [STEP_W+1:0]        sub;
   logic                     ge;
   logic [MAG_W-1:0]         dividend_mag;

   always_comb begin
      dividend_mag = dividend[DIFF_W-1] ? MAG_W'(-dividend) : MAG_W'(dividend);
      shifted      = {rem_ff[STEP_W-1:0], quo_ff[MAG_W-1]};
      sub          = {1'b0, shifted} - {2'b00, dsr_ff};
      ge           = !sub[STEP_W+1];
      busy_in  = busy_ff;
      done_in  = 1'b0;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      neg_in   = neg_ff;
      dsr_in   = dsr_ff;
      quot_in  = quot_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend_mag;
         neg_in   = dividend[DIFF_W-1];
         dsr_in   = divisor;
      end else if (busy_ff) begin
         rem_in   = ge ? sub[STEP_W:0] : shifted;
         quo_in   = {quo_ff[MAG_W-2:0], ge};
         count_in = count_ff + 1'b1;
         if (count_ff == CNT_W'(MAG_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            if (dsr_ff == '0) begin
               quot_in = '0;
            end else if (neg_ff) begin
               quot_in = -$signed({1'b0, quo_in});
            end else begin
               quot_in = $signed({1'b0, quo_in});
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
      rem_ff   <= rem_in;
      quo_ff   <= quo_in;
      neg_ff   <= neg_in;
      dsr_ff   <= dsr_in;
      quot_ff  <= quot_in;
   end

   assign done     = done_ff;
   assign quotient = quot_ff;

endmodule

FILE: rtl/pac_mac.sv
// shared multiplier with registered product and 64-bit accumulator
module pac_mac (
   input  logic                               clock,
   input  pac_pkg::mac_ctl_type               ctl,
   input  logic signed [pac_pkg::OPA_W-1:0]   op_a,
   input  logic signed [pac_pkg::OPB_W-1:0]   op_b,
   input  logic signed [pac_pkg::ACC_W-1:0]   base,
   output logic signed [pac_pkg::ACC_W-1:0]   acc
);
   import pac_pkg::*;

   logic signed [PROD_W-1:0] prod_ff, prod_in;
   logic signed [ACC_W-1:0]  acc_ff, acc_in;
   logic signed [ACC_W-1:0]  prod_wide;

   always_comb begin
      prod_in   = ctl.mul_en ? op_a * op_b : prod_ff;
      prod_wide = {{(ACC_W-PROD_W){prod_ff[PROD_W-1]}}, prod_ff};
      case (ctl.acc_op)
         MAC_HOLD:   acc_in = acc_ff;
         MAC_START:  acc_in = base + prod_wide;
         MAC_ADD:    acc_in = acc_ff + prod_wide;
         MAC_ADD_HI: acc_in = acc_ff + (prod_wide <<< HI_SHIFT);
         default:    acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      acc_ff  <= acc_in;
   end

   assign acc = acc_ff;

endmodule

FILE: rtl/pid_controller_antiwindup_core.sv
// top level of the pid controller with conditional-integration anti-windup
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_ready  req_err_sample
//   rsp      out        rsp_valid/rsp_ready  rsp_drive_out, rsp_clamped, rsp_held_integral
//   csr      in         csr_valid/csr_ready  csr_index, csr_wdata
//
// a request runs through 24 quotient steps of the serial divider, one step that picks up the
// quotient, ten steps of the shared multiplier and accumulator, one or two clamp steps and
// the output load. reset clears the integral, the previous error, the gains and the state;
// it loads the default step time and limits and clears the response valid flag.
// a pending response does not block the next request; only the output load waits.
`include "pid_controller_antiwindup_core_defines.svh"
module pid_controller_antiwindup_core (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_ready,
   input  logic signed [pac_pkg::ERR_W-1:0]       req_err_sample,
   output logic                                   rsp_valid,
   input  logic                                   rsp_ready,
   output logic signed [pac_pkg::OUT_W-1:0]       rsp_drive_out,
   output logic                                   rsp_clamped,
   output logic                                   rsp_held_integral,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  logic        [pac_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic        [pac_pkg::CSR_DAT_W-1:0]   csr_wdata
);
   import pac_pkg::*;

   state_type                state_ff, state_in;

   logic signed [GAIN_W-1:0] gain_p_ff, gain_i_ff, gain_d_ff;
   logic [STEP_W-1:0]        step_time_ff;
   logic signed [OUT_W-1:0]  out_min_ff, out_max_ff;

   logic signed [INTEG_W-1:0] integ_ff;
   logic signed [ERR_W-1:0]   last_err_ff;
   logic signed [ERR_W-1:0]   err_ff;
   logic signed [DIFF_W-1:0]  deriv_ff;
   logic signed [INTEG_W-1:0] trial_ff;
   logic signed [PD_W-1:0]    pd_ff;
   logic                      hit_ff, hold_ff;
   logic signed [OUT_W-1:0]   res_ff;

   logic                      rsp_valid_ff;
   logic signed [OUT_W-1:0]   rsp_drive_ff;
   logic                      rsp_clamped_ff, rsp_held_ff;

   logic                      req_fire, emit_fire;
   logic signed [DIFF_W-1:0]  diff;
   logic                      div_done;
   logic signed [DIFF_W-1:0]  div_quotient;

   mac_ctl_type               mac_ctl;
   logic signed [OPA_W-1:0]   mac_a;
   logic signed [OPB_W-1:0]   mac_b;
   logic signed [ACC_W-1:0]   mac_base;
   logic signed [ACC_W-1:0]   mac_acc;

   logic signed [INTEG_W-1:0] trial_sat;
   logic signed [ACC_W-1:0]   clamp_in;
   clamp_type                 clamp_res;
   logic                      hold_now;
   logic                      drive_in_limits;

   function automatic logic same_sign(input logic signed [ERR_W-1:0] e,
                                      input logic signed [ACC_W-1:0] s);
      logic e_zero;
      logic s_zero;
      e_zero = (e == '0);
      s_zero = (s == '0);
      return (e_zero && s_zero) ||
             (!e_zero && !s_zero && (e[ERR_W-1] == s[ACC_W-1]));
   endfunction

   assign req_ready = (state_ff == ST_IDLE);
   assign req_fire  = req_valid && req_ready;
   assign emit_fire = (state_ff == ST_EMIT) && (!rsp_valid_ff || rsp_ready);
   assign csr_ready = 1'b1;
   assign diff      = {req_err_sample[ERR_W-1], req_err_sample} -
                      {last_err_ff[ERR_W-1], last_err_ff};

   pac_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (req_fire),
      .dividend (diff),
      .divisor  (step_time_ff),
      .done     (div_done),
      .quotient (div_quotient)
   );

   pac_mac u_mac (
      .clock (clock),
      .ctl   (mac_ctl),
      .op_a  (mac_a),
      .op_b  (mac_b),
      .base  (mac_base),
      .acc   (mac_acc)
   );

   always_comb begin
      // trial integral saturates to the 48-bit range
      if (mac_acc[ACC_W-1:INTEG_W-1] == '0 || mac_acc[ACC_W-1:INTEG_W-1] == '1) begin
         trial_sat = mac_acc[INTEG_W-1:0];
      end else if (mac_acc[ACC_W-1]) begin
         trial_sat = {1'b1, {(INTEG_W-1){1'b0}}};
      end else begin
         trial_sat = {1'b0, {(INTEG_W-1){1'b1}}};
      end
      clamp_in  = (state_ff == ST_CLAMP_PD) ?
                  {{(ACC_W-PD_W){pd_ff[PD_W-1]}}, pd_ff} : mac_acc;
      clamp_res = clamp_q16(clamp_in, out_min_ff, out_max_ff);
      hold_now  = clamp_res.hit && same_sign(err_ff, mac_acc);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      mac_ctl  = '{mul_en: 1'b0, acc_op: MAC_HOLD};
      mac_a    = '0;
      mac_b    = '0;
      mac_base = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) state_in = ST_DIV;
         end
         ST_DIV: begin
            if (div_done) state_in = ST_MUL_EDT;
         end
         ST_MUL_EDT: begin
            mac_ctl.mul_en = 1'b1;
            mac_a    = {{(OPA_W-STEP_W){1'b0}}, step_time_ff};
            mac_b    = {err_ff[ERR_W-1], err_ff};
            state_in = ST_TRIAL;
         end
         ST_TRIAL: begin
            mac_ctl.acc_op = MAC_START;
            mac_base = {{(ACC_W-INTEG_W){integ_ff[INTEG_W-1]}}, integ_ff};
            state_in = ST_MUL_KP;
         end
         ST_MUL_KP: begin
            mac_ctl.mul_en = 1'b1;
            mac_a    = {gain_p_ff[GAIN_W-1], gain_p_ff};
            mac_b    = {err_ff[ERR_W-1], err_ff};
            state_in = ST_ACC_KP;
         end
         ST_ACC_KP: begin
            mac_ctl.acc_op = MAC_START;
            state_in = ST_MUL_KD;
         end
         ST_MUL_KD: begin
            mac_ctl.mul_en = 1'b1;
            mac_a    = {gain_d_ff[GAIN_W-1], gain_d_ff};
            mac_b    = deriv_ff;
            state_in = ST_ACC_KD;
         end
         ST_ACC_KD: begin
            mac_ctl.acc_op = MAC_ADD;
            state_in = ST_MUL_KIL;
         end
         ST_MUL_KIL: begin
            mac_ctl.mul_en = 1'b1;
            mac_a    = {gain_i_ff[GAIN_W-1], gain_i_ff};
            mac_b    = {1'b0, trial_ff[HI_SHIFT-1:0]};
            state_in = ST_ACC_KIL;
         end
         ST_ACC_KIL: begin
            mac_ctl.acc_op = MAC_ADD;
            state_in = ST_MUL_KIH;
         end
         ST_MUL_KIH: begin
            mac_ctl.mul_en = 1'b1;
            mac_a    = {gain_i_ff[GAIN_W-1], gain_i_ff};
            mac_b    = {{(OPB_W-(INTEG_W-HI_SHIFT)){trial_ff[INTEG_W-1]}},
                        trial_ff[INTEG_W-1:HI_SHIFT]};
            state_in = ST_ACC_KIH;
         end
         ST_ACC_KIH: begin
            mac_ctl.acc_op = MAC_ADD_HI;
            state_in = ST_CLAMP_SUM;
         end
         ST_CLAMP_SUM: begin
            state_in = hold_now ? ST_CLAMP_PD : ST_EMIT;
         end
         ST_CLAMP_PD: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (emit_fire) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gain_p_ff    <= '0;
         gain_i_ff    <= '0;
         gain_d_ff    <= '0;
         step_time_ff <= STEP_TIME_RESET;
         out_min_ff   <= OUT_MIN_RESET;
         out_max_ff   <= OUT_MAX_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_GAIN_P:    gain_p_ff    <= csr_wdata;
            CSR_GAIN_I:    gain_i_ff    <= csr_wdata;
            CSR_GAIN_D:    gain_d_ff    <= csr_wdata;
            CSR_STEP_TIME: step_time_ff <= csr_wdata[STEP_W-1:0];
            CSR_OUT_MIN:   out_min_ff   <= csr_wdata;
            CSR_OUT_MAX:   out_max_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // controller state
   always_ff @(posedge clock) begin
      if (reset) begin
         integ_ff    <= '0;
         last_err_ff <= '0;
      end else if (state_ff == ST_CLAMP_SUM) begin
         last_err_ff <= err_ff;
         if (!hold_now) integ_ff <= trial_ff;
      end
   end

   // working registers
   always_ff @(posedge clock) begin
      if (req_fire) err_ff <= req_err_sample;
      if (state_ff == ST_DIV && div_done) deriv_ff <= div_quotient;
      if (state_ff == ST_MUL_KP) trial_ff <= trial_sat;
      if (state_ff == ST_MUL_KIL) pd_ff <= mac_acc[PD_W-1:0];
      if (state_ff == ST_CLAMP_SUM) begin
         hit_ff  <= clamp_res.hit;
         hold_ff <= hold_now;
         res_ff  <= clamp_res.value;
      end
      if (state_ff == ST_CLAMP_PD) res_ff <= clamp_res.value;
   end

   // output stage
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit_fire) begin
         rsp_drive_ff   <= res_ff;
         rsp_clamped_ff <= hit_ff;
         rsp_held_ff    <= hold_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_drive_out     = rsp_drive_ff;
   assign rsp_clamped       = rsp_clamped_ff;
   assign rsp_held_integral = rsp_held_ff;

   assign drive_in_limits = (rsp_drive_out >= out_min_ff) && (rsp_drive_out <= out_max_ff);

   `PAC_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)
   `PAC_ASSERT_NOW(a_div_done_in_wait, div_done, state_ff == ST_DIV)
   `PAC_ASSERT_NOW(a_hold_needs_clamp, rsp_valid && rsp_held_integral, rsp_clamped)
   `PAC_ASSERT_NOW(a_free_within_limits, rsp_valid && !rsp_clamped, drive_in_limits)

endmodule

FILE: verif/testbench.sv
// self-checking testbench for the pid anti-windup core: directed table, random phases, windup
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import pac_pkg::*;

   typedef struct packed {
      logic signed [OUT_W-1:0] drive;
      logic                    clamped;
      logic                    held;
   } drive_result_type;

   typedef enum logic {ROW_CSR, ROW_ERR} row_kind_type;

   typedef struct packed {
      row_kind_type            kind;
      csr_index_type           csr_idx;
      logic [CSR_DAT_W-1:0]    wdata;
      logic signed [ERR_W-1:0] err;
      logic                    typed;
      drive_result_type        want;
   } stim_row_type;

   localparam longint INTEG_TOP    = 64'sh0000_7FFF_FFFF_FFFF;
   localparam longint INTEG_BOTTOM = -INTEG_TOP - 1;
   localparam logic signed [ERR_W-1:0] ERR_TOP    = 24'sh7F_FFFF;
   localparam logic signed [ERR_W-1:0] ERR_BOTTOM = 24'sh80_0000;
   localparam int N_ROWS = 28;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    req_valid = 1'b0;
   logic                    req_ready;
   logic signed [ERR_W-1:0] req_err_sample = '0;
   logic                    rsp_valid;
   logic                    rsp_ready = 1'b0;
   logic signed [OUT_W-1:0] rsp_drive_out;
   logic                    rsp_clamped;
   logic                    rsp_held_integral;
   logic                    csr_valid = 1'b0;
   logic                    csr_ready;
   csr_index_type           csr_index = CSR_GAIN_P;
   logic [CSR_DAT_W-1:0]    csr_wdata = '0;

   logic signed [GAIN_W-1:0] cfg_gain_p = '0;
   logic signed [GAIN_W-1:0] cfg_gain_i = '0;
   logic signed [GAIN_W-1:0] cfg_gain_d = '0;
   logic [STEP_W-1:0]        cfg_step_time = STEP_TIME_RESET;
   logic signed [OUT_W-1:0]  cfg_out_min = OUT_MIN_RESET;
   logic signed [OUT_W-1:0]  cfg_out_max = OUT_MAX_RESET;
   longint                   pred_integ = 0;
   longint                   pred_last_err = 0;

   drive_result_type         expected_drive_q [$];
   int                       mismatch_count = 0;
   int                       idle_pct = 10;
   logic signed [ERR_W-1:0]  recent_err = '0;

   stim_row_type stim_table [N_ROWS] = '{
      '{ROW_ERR, CSR_GAIN_P, 16'h0000, 24'h000000, 1'b1, '{16'sd0, 1'b0, 1'b0}},
      '{ROW_ERR, CSR_GAIN_P, 16'h0000, 24'h7FFFFF, 1'b1, '{16'sd0, 1'b0, 1'b0}},
      '{ROW_ERR, CSR_GAIN_P, 16'h0000, 24'h800000, 1'b1, '{16'sd0, 1'b0, 1'b0}},
      '{ROW_CSR, CSR_GAIN_P, 16'h7FFF, 24'h000000, 1'b0, '0},
      '{ROW_ERR, CSR_GAIN_P, 16'h0000, 24'h7FFFFF, 1'b1, '{16'sd25600, 1'b1, 1'b1}},
      '{ROW_ERR, CSR_GAIN_P, 16'h0000, 24'h800000, 1'b1, '{-16'sd25600, 1'b1, 1'b1}},
      '{ROW_ERR, CSR_GAIN_P, 16'h0000, 24'h000001, 1'b0, '0},
      '{ROW_ERR, CSR_GAIN_P, 16'h0000, 24'hFFFFFF, 1'b0, '0},
      '{ROW_CSR, CSR_GAIN_P, 16'h8000, 24'h000000, 1'b0, '0},
      '{ROW_CSR, CSR_GAIN_I, 16'h7FFF, 24'h000000, 1'b0, '0},
      '{ROW_CSR, CSR_GAIN_D, 16'h7FFF, 24'h000000, 1'b0, '0},
      '{ROW_CSR, CSR_STEP_TIME, 16'hFFFF, 24'h000000, 1'b0, '0},
      '{ROW_CSR, CSR_OUT_MIN, 16'h8000, 24'h000000, 1'b0, '0},
      '{ROW_CSR, CSR_OUT_MAX, 16'h7FFF, 24'h000000, 1'b0, '0},
      '{ROW_ERR, CSR_GAIN_P, 16'h0000, 24'h7FFFFF, 1'b0, '0},
      '{ROW_ERR, CSR_GAIN_P, 16'h0000, 24'h800000, 1'b0, '0},
      '{ROW_ERR, CSR_GAIN_P, 16'h0000, 24'h000000, 1'b0, '0},
      '{ROW_ERR, CSR_GAIN_P, 16'h0000, 24'h000100, 1'b0, '0},
      '{ROW_ERR, CSR_GAIN_P, 16'h0000, 24'hFFFED4, 1'b0, '0},
      '{ROW_CSR, CSR_STEP_TIME, 16'h0000, 24'h000000, 1'b0, '0},
      '{ROW_CSR, CSR_GAIN_P, 16'h0100, 24'h000000, 1'b0, '0},
      '{ROW_CSR, CSR_GAIN_I, 16'h0000, 24'h000000, 1'b0, '0},
      '{ROW_CSR, CSR_GAIN_D, 16'h0100, 24'h000000, 1'b0, '0},
      '{ROW_CSR, CSR_OUT_MIN, 16'h0100, 24'h000000, 1'b0, '0},
      '{ROW_CSR, CSR_OUT_MAX, 16'hFF00, 24'h000000, 1'b0, '0},
      '{ROW_ERR, CSR_GAIN_P, 16'h0000, 24'h000000, 1'b1, '{-16'sd256, 1'b1, 1'b1}},
      '{ROW_ERR, CSR_GAIN_P, 16'h0000, 24'h0003E8, 1'b1, '{-16'sd256, 1'b1, 1'b1}},
      '{ROW_ERR, CSR_GAIN_P, 16'h0000, 24'hFFFC18, 1'b1, '{16'sd256, 1'b1, 1'b1}}
   };

   pid_controller_antiwindup_core u_top (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_err_sample    (req_err_sample),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_drive_out     (rsp_drive_out),
      .rsp_clamped       (rsp_clamped),
      .rsp_held_integral (rsp_held_integral),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic int sign_of(input longint v);
      return (v > 0) ? 1 : ((v < 0) ? -1 : 0);
   endfunction

   function automatic logic signed [OUT_W-1:0] clamp_out(input longint s, output logic hit);
      logic signed [OUT_W-1:0] o;
      o   = OUT_W'(s >>> FRAC_W);
      hit = 1'b0;
      if (s < longint'(cfg_out_min) * 256) begin
         o   = cfg_out_min;
         hit = 1'b1;
      end
      if (s > longint'(cfg_out_max) * 256) begin
         o   = cfg_out_max;
         hit = 1'b1;
      end
      return o;
   endfunction

   function automatic drive_result_type pid_predict(input logic signed [ERR_W-1:0] err);
      longint           e;
      longint           dt;
      longint           trial;
      longint           deriv;
      longint           pd;
      longint           sum;
      logic             hit;
      logic             hit_pd;
      drive_result_type r;
      e     = longint'(err);
      dt    = longint'(cfg_step_time);
      trial = pred_integ + e * dt;
      if (trial > INTEG_TOP) trial = INTEG_TOP;
      if (trial < INTEG_BOTTOM) trial = INTEG_BOTTOM;
      deriv = (dt != 0) ? (e - pred_last_err) / dt : 0;
      pd    = longint'(cfg_gain_p) * e + longint'(cfg_gain_d) * deriv;
      sum   = pd + longint'(cfg_gain_i) * trial;
      pred_last_err = e;
      r.drive   = clamp_out(sum, hit);
      r.clamped = hit;
      r.held    = hit && (sign_of(e) == sign_of(sum));
      if (r.held) begin
         r.drive = clamp_out(pd, hit_pd);
      end else begin
         pred_integ = trial;
      end
      return r;
   endfunction

   function automatic logic [CSR_DAT_W-1:0] pick_gain();
      case ($urandom_range(3))
         0: begin
            case ($urandom_range(2))
               0: return 16'h7FFF;
               1: return 16'h8000;
               default: return 16'h0000;
            endcase
         end
         1: return 16'($urandom_range(1024) - 512);
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DAT_W-1:0] pick_step();
      logic [STEP_W-1:0] st;
      case ($urandom_range(4))
         0: st = '0;
         1: st = 10'd1;
         2: st = 10'd1023;
         3: st = 10'($urandom_range(30, 1));
         default: st = 10'($urandom_range(1023, 1));
      endcase
      return {6'($urandom), st};
   endfunction

   function automatic logic signed [ERR_W-1:0] pick_err(input logic signed [ERR_W-1:0] prev);
      case ($urandom_range(9))
         0, 1, 2: return ERR_W'($urandom);
         3, 4, 5: return ERR_W'($urandom_range(4096) - 2048);
         6: begin
            case ($urandom_range(4))
               0: return ERR_TOP;
               1: return ERR_BOTTOM;
               2: return '0;
               3: return 24'sd1;
               default: return -24'sd1;
            endcase
         end
         default: return prev + ERR_W'($urandom_range(512) - 256);
      endcase
   endfunction

   task automatic send_err(input logic signed [ERR_W-1:0] e, input logic typed,
                           input drive_result_type want);
      drive_result_type got;
      if ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < idle_pct);
      end
      req_valid      <= 1'b1;
      req_err_sample <= e;
      do @(posedge clock); while (!req_ready);
      got = pid_predict(e);
      expected_drive_q.push_back(typed ? want : got);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (expected_drive_q.size() != 0) @(posedge clock);
      @(posedge clock);
   endtask

   task automatic csr_write(input csr_index_type idx, input logic [CSR_DAT_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      case (idx)
         CSR_GAIN_P: cfg_gain_p = data;
         CSR_GAIN_I: cfg_gain_i = data;
         CSR_GAIN_D: cfg_gain_d = data;
         CSR_STEP_TIME: cfg_step_time = data[STEP_W-1:0];
         CSR_OUT_MIN: cfg_out_min = data;
         CSR_OUT_MAX: cfg_out_max = data;
         default: ;
      endcase
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic load_settings(input logic [CSR_DAT_W-1:0] gp, input logic [CSR_DAT_W-1:0] gi,
                                input logic [CSR_DAT_W-1:0] gd, input logic [CSR_DAT_W-1:0] st,
                                input logic [CSR_DAT_W-1:0] lo, input logic [CSR_DAT_W-1:0] hi);
      csr_write(CSR_GAIN_P, gp);
      csr_write(CSR_GAIN_I, gi);
      csr_write(CSR_GAIN_D, gd);
      csr_write(CSR_STEP_TIME, st);
      csr_write(CSR_OUT_MIN, lo);
      csr_write(CSR_OUT_MAX, hi);
   endtask

   always @(posedge clock) begin
      rsp_ready <= ($urandom_range(99) >= idle_pct);
   end

   always @(posedge clock) begin
      drive_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_drive_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("unexpected response: drive %0d clamped %0b held %0b",
                        rsp_drive_out, rsp_clamped, rsp_held_integral);
         end else begin
            want = expected_drive_q.pop_front();
            if (rsp_drive_out !== want.drive || rsp_clamped !== want.clamped ||
                rsp_held_integral !== want.held) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("response mismatch: expected %0d/%0b/%0b, got %0d/%0b/%0b",
                           want.drive, want.clamped, want.held,
                           rsp_drive_out, rsp_clamped, rsp_held_integral);
            end
         end
      end
   end

   initial begin
      logic signed [ERR_W-1:0] next_err;
      logic [CSR_DAT_W-1:0]    lim_a;
      logic [CSR_DAT_W-1:0]    lim_b;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (stim_table[i]) begin
         if (stim_table[i].kind == ROW_CSR) begin
            drain();
            csr_write(stim_table[i].csr_idx, stim_table[i].wdata);
         end else begin
            send_err(stim_table[i].err, stim_table[i].typed, stim_table[i].want);
         end
      end

      for (int phase = 0; phase < 6; phase++) begin
         drain();
         idle_pct = (phase == 2) ? 0 : 10;
         case ($urandom_range(3))
            0: begin
               lim_a = OUT_MIN_RESET;
               lim_b = OUT_MAX_RESET;
            end
            1: begin
               lim_a = 16'h8000;
               lim_b = 16'h7FFF;
            end
            2: begin
               lim_a = 16'($urandom);
               lim_b = 16'($urandom);
               if ($signed(lim_a) > $signed(lim_b)) begin
                  lim_a = lim_a ^ lim_b;
                  lim_b = lim_a ^ lim_b;
                  lim_a = lim_a ^ lim_b;
               end
            end
            default: begin
               lim_a = 16'($urandom);
               lim_b = 16'($urandom);
            end
         endcase
         if (phase == 0) begin
            load_settings(16'h7FFF, 16'h8000, 16'h7FFF, 16'h0001, 16'h8000, 16'h7FFF);
         end else if (phase == 1) begin
            load_settings(16'($urandom_range(512) - 256), 16'($urandom_range(8)),
                          16'($urandom_range(512) - 256), pick_step(), lim_a, lim_b);
         end else begin
            load_settings(pick_gain(), pick_gain(), pick_gain(), pick_step(), lim_a, lim_b);
         end
         repeat (65) begin
            if ($urandom_range(39) == 0) drain();
            next_err = pick_err(recent_err);
            send_err(next_err, 1'b0, '0);
            recent_err = next_err;
         end
      end

      // drive the integral high with large errors, then make it visible through a negative gain
      drain();
      idle_pct = 10;
      load_settings(16'h0000, 16'h0000, 16'h0000, 16'd1023, OUT_MIN_RESET, OUT_MAX_RESET);
      repeat (12) send_err(ERR_W'($urandom_range(8388607, 7340032)), 1'b0, '0);
      repeat (8) send_err(ERR_TOP, 1'b0, '0);
      drain();
      csr_write(CSR_GAIN_I, 16'hFFFF);
      repeat (12) send_err(ERR_W'($urandom_range(8388607, 4194304)), 1'b0, '0);
      repeat (4) send_err(ERR_BOTTOM, 1'b0, '0);

      drain();
      repeat (100) @(posedge clock);
      if (mismatch_count == 0 && expected_drive_q.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   initial begin
      #40_000_000;
      $display("TEST FAILED");
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/pac_pkg.sv
rtl/pac_div.sv
rtl/pac_mac.sv
rtl/pid_controller_antiwindup_core.sv
verif/testbench.sv
